/* sv/signed_int_to_base_digits_defines.svh */
// ----------------------------------------------------------------------------
// signed_int_to_base_digits_defines.svh
// Assertion macros shared by the checker of the digit converter.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_BASE_DIGITS_DEFINES_SVH
`define SIGNED_INT_TO_BASE_DIGITS_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define SITBD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define SITBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/sitbd_pkg.sv */
// ----------------------------------------------------------------------------
// sitbd_pkg
// Shared constants and controller/datapath interface types of the
// signed integer to digit text converter.
// ----------------------------------------------------------------------------
package sitbd_pkg;

  localparam int DEF_MAX_RADIX  = 16;
  localparam int DEF_VALUE_BITS = 32;

  localparam int CHAR_W      = 8;
  localparam int RADIX_W     = 5;
  localparam int ALPHA_CHARS = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SIZE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_HIGH = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CHAR_FIRST = 8'h21;
  localparam logic [CHAR_W-1:0] CHAR_LAST  = 8'h7e;
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

  typedef struct packed {
    logic load;       // take a new value in
    logic step;       // one restoring division step
    logic store;      // push the remainder as a digit, restart the divider
    logic put_sign;   // load a minus sign into the output register
    logic put_digit;  // load the fetched digit into the output register
    logic put_err;    // load the error result into the output register
  } sitbd_cmd_t;

  typedef struct packed {
    logic bad;         // alphabet or radix is invalid
    logic neg;         // the current value is negative
    logic div_last;    // the divider is on its final bit
    logic quo_zero;    // the quotient is zero
    logic last_digit;  // one digit left to emit
    logic out_free;    // the output register can take a result
  } sitbd_status_t;

endpackage

/* sv/signed_int_to_base_digits.sv */
// ----------------------------------------------------------------------------
// signed_int_to_base_digits
// Writes a signed integer out as text in a configured radix, one character
// per result item, with a leading minus sign for negative values.
//
// An item is taken in and its alphabet checked; each digit then comes from the
// restoring divider, one quotient bit per cycle, and the digits are emitted
// from the registered digit stack, each read and then put out, after a minus
// sign for a negative value. An item with an invalid alphabet gives a lone
// error result. A new item is taken once the previous one has placed its last
// character in the output register.
// Configure base_size and the alphabet while no item is in flight.
// ----------------------------------------------------------------------------
module signed_int_to_base_digits #(
  parameter int MAX_RADIX  = sitbd_pkg::DEF_MAX_RADIX,
  parameter int VALUE_BITS = sitbd_pkg::DEF_VALUE_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sitbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sitbd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [VALUE_BITS-1:0]     value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [sitbd_pkg::CHAR_W-1:0]     character,
  output logic                             last,
  output logic                             bad_alphabet
);

  sitbd_pkg::sitbd_cmd_t    cmd;
  sitbd_pkg::sitbd_status_t status;

  assign cfg_ready = 1'b1;

  sitbd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  sitbd_datapath #(
    .MAX_RADIX (MAX_RADIX),
    .VALUE_BITS(VALUE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .value       (value),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .character   (character),
    .last        (last),
    .bad_alphabet(bad_alphabet)
  );

endmodule

/* sv/sitbd_ram.sv */
// ----------------------------------------------------------------------------
// sitbd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sitbd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/sitbd_datapath.sv */
// ----------------------------------------------------------------------------
// sitbd_datapath
// Configuration registers, alphabet check, bit-serial restoring divider,
// digit stack and output register.
// ----------------------------------------------------------------------------
module sitbd_datapath #(
  parameter int MAX_RADIX  = sitbd_pkg::DEF_MAX_RADIX,
  parameter int VALUE_BITS = sitbd_pkg::DEF_VALUE_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic [sitbd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sitbd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic signed [VALUE_BITS-1:0]         value,
  input  sitbd_pkg::sitbd_cmd_t                cmd,
  output sitbd_pkg::sitbd_status_t             status,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [sitbd_pkg::CHAR_W-1:0]         character,
  output logic                                 last,
  output logic                                 bad_alphabet
);

  localparam int DIGIT_W = $clog2(MAX_RADIX);
  localparam int ADDR_W  = $clog2(VALUE_BITS);
  localparam int CNT_W   = $clog2(VALUE_BITS + 1);
  localparam int RW      = sitbd_pkg::RADIX_W;
  localparam logic [7:0] RADIX_CAP =
    8'((MAX_RADIX < sitbd_pkg::ALPHA_CHARS) ? MAX_RADIX : sitbd_pkg::ALPHA_CHARS);

  logic [RW-1:0]                       base_size;
  logic [sitbd_pkg::CFG_DATA_W-1:0]    alphabet_low;
  logic [sitbd_pkg::CFG_DATA_W-1:0]    alphabet_high;
  logic [sitbd_pkg::CHAR_W-1:0]        alpha [sitbd_pkg::ALPHA_CHARS];

  logic                  bad;
  logic                  neg;
  logic [VALUE_BITS-1:0] mag;
  logic [VALUE_BITS-1:0] mag_next;
  logic [VALUE_BITS-1:0] value_u;
  logic [RW-1:0]         rem;
  logic [RW-1:0]         rem_next;
  logic [RW:0]           partial;
  logic                  qbit;
  logic [ADDR_W-1:0]     bit_cnt;
  logic [CNT_W-1:0]      nd;
  logic [CNT_W-1:0]      nd_prev;
  logic [7:0]            rem_ext;
  logic [DIGIT_W-1:0]    rd_digit;
  logic [7:0]            digit_ext;
  logic [sitbd_pkg::CHAR_W-1:0] digit_char;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_size     <= '0;
      alphabet_low  <= '0;
      alphabet_high <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        sitbd_pkg::CFG_BASE_SIZE:     base_size     <= cfg_data[RW-1:0];
        sitbd_pkg::CFG_ALPHABET_LOW:  alphabet_low  <= cfg_data;
        sitbd_pkg::CFG_ALPHABET_HIGH: alphabet_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      alpha[k]     = alphabet_low[8*k +: 8];
      alpha[k + 8] = alphabet_high[8*k +: 8];
    end
  end

  // The alphabet is valid when the radix is in range and every character in
  // use is printable, not a sign, and unique.
  always_comb begin
    bad = (base_size < RW'(2)) || ({3'b000, base_size} > RADIX_CAP);
    for (int i = 0; i < sitbd_pkg::ALPHA_CHARS; i++) begin
      if (RW'(i) < base_size) begin
        if (alpha[i] == sitbd_pkg::CHAR_MINUS || alpha[i] == sitbd_pkg::CHAR_PLUS ||
            alpha[i] < sitbd_pkg::CHAR_FIRST || alpha[i] > sitbd_pkg::CHAR_LAST) begin
          bad = 1'b1;
        end
        for (int j = i + 1; j < sitbd_pkg::ALPHA_CHARS; j++) begin
          if (RW'(j) < base_size && alpha[j] == alpha[i]) begin
            bad = 1'b1;
          end
        end
      end
    end
  end

  // One restoring division step: the quotient bit shifts into mag from the
  // bottom while the dividend bits leave from the top.
  assign value_u  = $unsigned(value);
  assign partial  = {rem, mag[VALUE_BITS-1]};
  assign qbit     = (partial >= {1'b0, base_size});
  assign rem_next = qbit ? RW'(partial - {1'b0, base_size}) : partial[RW-1:0];
  assign mag_next = {mag[VALUE_BITS-2:0], qbit};

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt <= '0;
      nd      <= '0;
    end else if (cmd.load) begin
      neg     <= value_u[VALUE_BITS-1];
      // Negating as unsigned keeps the most negative value exact.
      mag     <= value_u[VALUE_BITS-1] ? (~value_u + VALUE_BITS'(1)) : value_u;
      rem     <= '0;
      bit_cnt <= '0;
      nd      <= '0;
    end else if (cmd.step) begin
      mag     <= mag_next;
      rem     <= rem_next;
      bit_cnt <= bit_cnt + ADDR_W'(1);
    end else if (cmd.store) begin
      rem     <= '0;
      bit_cnt <= '0;
      nd      <= nd + CNT_W'(1);
    end else if (cmd.put_digit) begin
      nd      <= nd_prev;
    end
  end

  // Digits are stacked least significant first and read back from the top.
  assign rem_ext = {3'b000, rem};
  assign nd_prev = nd - CNT_W'(1);

  sitbd_ram #(
    .WIDTH(DIGIT_W),
    .DEPTH(VALUE_BITS)
  ) u_digits (
    .clk  (clk),
    .we   (cmd.store),
    .waddr(nd[ADDR_W-1:0]),
    .wdata(rem_ext[DIGIT_W-1:0]),
    .raddr(nd_prev[ADDR_W-1:0]),
    .rdata(rd_digit)
  );

  assign digit_ext  = {{(8 - DIGIT_W){1'b0}}, rd_digit};
  assign digit_char = (digit_ext < 8'(sitbd_pkg::ALPHA_CHARS)) ? alpha[digit_ext[3:0]]
                                                               : sitbd_pkg::CHAR_NONE;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.put_sign || cmd.put_digit || cmd.put_err) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put_sign) begin
      character    <= sitbd_pkg::CHAR_MINUS;
      last         <= 1'b0;
      bad_alphabet <= 1'b0;
    end else if (cmd.put_digit) begin
      character    <= digit_char;
      last         <= (nd == CNT_W'(1));
      bad_alphabet <= 1'b0;
    end else if (cmd.put_err) begin
      character    <= sitbd_pkg::CHAR_NONE;
      last         <= 1'b1;
      bad_alphabet <= 1'b1;
    end
  end

  assign status.bad        = bad;
  assign status.neg        = neg;
  assign status.div_last   = (bit_cnt == ADDR_W'(VALUE_BITS - 1));
  assign status.quo_zero   = (mag == '0);
  assign status.last_digit = (nd == CNT_W'(1));
  assign status.out_free   = !out_valid || out_ready;

endmodule

/* sv/sitbd_ctrl.sv */
// ----------------------------------------------------------------------------
// sitbd_ctrl
// Sequencer: alphabet check, repeated division, then emission of the sign and
// the digits from most significant down, or of the error result.
// ----------------------------------------------------------------------------
module sitbd_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  sitbd_pkg::sitbd_status_t status,
  output sitbd_pkg::sitbd_cmd_t    cmd
);

  localparam logic [2:0] IDLE  = 3'd0;
  localparam logic [2:0] CHECK = 3'd1;
  localparam logic [2:0] DIV   = 3'd2;
  localparam logic [2:0] STORE = 3'd3;
  localparam logic [2:0] SIGN  = 3'd4;
  localparam logic [2:0] FETCH = 3'd5;
  localparam logic [2:0] PUT   = 3'd6;
  localparam logic [2:0] ERR   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = CHECK;
        end
      end
      CHECK: begin
        state_next = status.bad ? ERR : DIV;
      end
      DIV: begin
        cmd.step = 1'b1;
        if (status.div_last) begin
          state_next = STORE;
        end
      end
      STORE: begin
        cmd.store = 1'b1;
        if (!status.quo_zero) begin
          state_next = DIV;
        end else begin
          state_next = status.neg ? SIGN : FETCH;
        end
      end
      SIGN: begin
        if (status.out_free) begin
          cmd.put_sign = 1'b1;
          state_next   = FETCH;
        end
      end
      FETCH: begin
        // The digit read address settles here; the registered read data is ready in PUT.
        state_next = PUT;
      end
      PUT: begin
        if (status.out_free) begin
          cmd.put_digit = 1'b1;
          state_next    = status.last_digit ? IDLE : FETCH;
        end
      end
      ERR: begin
        if (status.out_free) begin
          cmd.put_err = 1'b1;
          state_next  = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

endmodule

/* sv/sitbd_checker.sv */
// ----------------------------------------------------------------------------
// sitbd_checker
// Port-level checks of the digit converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "signed_int_to_base_digits_defines.svh"

module sitbd_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [sitbd_pkg::CHAR_W-1:0] character,
  input logic                         last,
  input logic                         bad_alphabet
);

  // A result waiting for the sink keeps its payload.
  `SITBD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(character) && $stable(last) && $stable(bad_alphabet), "output changed while stalled")

  // The error result is a lone zero character that closes its item.
  `SITBD_ASSERT_NOW(a_err_form, out_valid && bad_alphabet, last && character == sitbd_pkg::CHAR_NONE, "malformed error result")

  // A minus sign is always followed by at least one digit.
  `SITBD_ASSERT_NOW(a_sign_not_last, out_valid && !bad_alphabet && character == sitbd_pkg::CHAR_MINUS, !last, "minus sign marked last")

  // Once an item is taken, the next one waits until its last character is placed.
  `SITBD_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")

endmodule

bind signed_int_to_base_digits sitbd_checker u_sitbd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .character   (character),
  .last        (last),
  .bad_alphabet(bad_alphabet)
);
